[src/s2u_pkg.sv]
`default_nettype none

package s2u_pkg;

    localparam int S2U_MAX_CHARS = 4095;

    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;

    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] LOWER_BIAS = 8'h57;
    localparam logic [7:0] UPPER_BIAS = 8'h37;

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_FIRST      = 7'b0000010,
        PH_AFTER_SIGN = 7'b0000100,
        PH_ZERO_SEEN  = 7'b0001000,
        PH_HEX_FIRST  = 7'b0010000,
        PH_DIGITS     = 7'b0100000,
        PH_DONE       = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        ANY_NONE = 2'd0,
        ANY_SOME = 2'd1,
        ANY_OVER = 2'd2
    } any_t;

    typedef struct packed {
        phase_t      phase;
        logic [63:0] accumulator;
        logic        negative_sign;
        logic [5:0]  effective_base;
        any_t        any_status;
    } parse_state_t;

    typedef struct packed {
        logic       string_start;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic [63:0] parsed_value;
        logic [11:0] end_offset;
        logic        digits_seen;
        logic        overflow_flag;
    } out_item_t;

endpackage

`default_nettype wire

[src/s2u_parse_core.sv]
`default_nettype none

module s2u_parse_core
    import s2u_pkg::*;
#(
    parameter int MAX_CHARS = S2U_MAX_CHARS
)
(
    input  wire logic                                string_start,
    input  wire logic [7:0]                          char_code,
    input  wire logic [5:0]                          number_base,
    input  wire parse_state_t                        state,
    input  wire logic [$clog2(MAX_CHARS + 1) - 1:0]  position,
    output parse_state_t                             state_next,
    output logic      [$clog2(MAX_CHARS + 1) - 1:0]  position_next,
    output logic                                     fire,
    output out_item_t                                result
);

    localparam int POS_W = $clog2(MAX_CHARS + 1);

    parse_state_t     s;
    logic [POS_W-1:0] p;
    logic             go_after;
    logic             take;
    logic [5:0]       base;
    logic [7:0]       dig_full;
    logic             dig_ok;
    logic [69:0]      prod;
    logic [69:0]      sum;
    logic [31:0]      pos_wide;

    always_comb
    begin
        s        = state;
        p        = position;
        go_after = 1'b0;
        take     = 1'b0;
        base     = BASE_DEC;
        dig_full = 8'd0;
        dig_ok   = 1'b0;
        prod     = '0;
        sum      = '0;
        pos_wide = '0;
        fire     = 1'b0;
        result   = '0;

        if (string_start)
        begin
            s.phase          = PH_FIRST;
            s.accumulator    = '0;
            s.negative_sign  = 1'b0;
            s.any_status     = ANY_NONE;
            s.effective_base = number_base;
            p                = '0;
        end
        else if (state.phase inside {PH_FIRST, PH_AFTER_SIGN, PH_ZERO_SEEN, PH_HEX_FIRST,
                                     PH_DIGITS})
        begin
            if (p < POS_W'(MAX_CHARS))
                p = p + POS_W'(1);
            else
                p = POS_W'(MAX_CHARS);
        end

        case (s.phase)
            PH_FIRST:
            begin
                if (char_code == CH_MINUS)
                begin
                    s.negative_sign = 1'b1;
                    s.phase         = PH_AFTER_SIGN;
                end
                else if (char_code == CH_PLUS)
                    s.phase = PH_AFTER_SIGN;
                else
                    go_after = 1'b1;
            end
            PH_AFTER_SIGN:
                go_after = 1'b1;
            PH_ZERO_SEEN:
            begin
                if (char_code == CH_LOWER_X || char_code == CH_UPPER_X)
                begin
                    s.effective_base = BASE_HEX;
                    s.phase          = PH_HEX_FIRST;
                end
                else
                begin
                    // The leading zero counts as a converted digit.
                    if (s.effective_base == BASE_AUTO)
                        s.effective_base = BASE_OCT;
                    s.phase      = PH_DIGITS;
                    s.any_status = ANY_SOME;
                    take         = 1'b1;
                end
            end
            PH_HEX_FIRST, PH_DIGITS:
            begin
                s.phase = PH_DIGITS;
                take    = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (go_after)
        begin
            if ((s.effective_base == BASE_AUTO || s.effective_base == BASE_HEX) &&
                char_code == CH_ZERO)
                s.phase = PH_ZERO_SEEN;
            else
            begin
                if (s.effective_base == BASE_AUTO)
                    s.effective_base = BASE_DEC;
                s.phase = PH_DIGITS;
                take    = 1'b1;
            end
        end

        if (take)
        begin
            base = (s.effective_base == BASE_AUTO) ? BASE_DEC : s.effective_base;
            if (char_code inside {[CH_ZERO:CH_NINE]})
            begin
                dig_full = char_code - CH_ZERO;
                dig_ok   = 1'b1;
            end
            else if (char_code inside {[CH_LOWER_A:CH_LOWER_Z]})
            begin
                dig_full = char_code - LOWER_BIAS;
                dig_ok   = 1'b1;
            end
            else if (char_code inside {[CH_UPPER_A:CH_UPPER_Z]})
            begin
                dig_full = char_code - UPPER_BIAS;
                dig_ok   = 1'b1;
            end

            if (!dig_ok || dig_full[5:0] >= base)
            begin
                fire     = 1'b1;
                pos_wide = 32'(p);
                if (s.any_status == ANY_OVER)
                    result.parsed_value = '1;
                else if (s.negative_sign)
                    result.parsed_value = 64'd0 - s.accumulator;
                else
                    result.parsed_value = s.accumulator;
                result.end_offset    = (s.any_status != ANY_NONE) ? pos_wide[11:0] : 12'd0;
                result.digits_seen   = (s.any_status != ANY_NONE);
                result.overflow_flag = (s.any_status == ANY_OVER);
                s.phase              = PH_DONE;
            end
            else
            begin
                // Overflow exactly when the new value no longer fits in 64 bits.
                prod = 70'(s.accumulator) * 70'(base);
                sum  = prod + 70'(dig_full[5:0]);
                if (s.any_status == ANY_OVER || sum[69:64] != 6'd0)
                    s.any_status = ANY_OVER;
                else
                begin
                    s.any_status  = ANY_SOME;
                    s.accumulator = sum[63:0];
                end
            end
        end

        state_next    = s;
        position_next = p;
    end

endmodule

`default_nettype wire

[src/string_to_u64_parser.sv]
// String to unsigned 64-bit converter.
// Characters enter on the input channel (in_valid, in_stall, in_item), one byte per
// request; string_start marks the first byte of a new string. An optional sign and an
// optional 0x or 0X prefix (base 0 or 16 only) are parsed, then digits in the configured
// base, where base 0 selects 8, 10 or 16 from the prefix. The first byte that is not a
// digit produces one request on the output channel (out_valid, out_stall, out_item) with
// the value, the end offset and the digit and overflow flags. Later bytes are ignored
// until the next start. The base is written on the configuration channel (cfg_valid,
// cfg_ready, cfg_data), which is always ready, and is latched at each string start.
// A byte is registered in in_item_reg when it is accepted and is processed from there
// once the output register can move; its result and out_valid are then registered. One
// byte per cycle is sustained while no result is stalled; the digit step is a single
// 64 by 6 multiply-add. A stalled result holds in the output register; a byte that is
// already registered waits behind it, and in_stall rises only while both are occupied.
// Reset clears all control state and sets the base to automatic.
`default_nettype none

module string_to_u64_parser
    import s2u_pkg::*;
#(
    parameter int MAX_CHARS = S2U_MAX_CHARS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [5:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_item_t   in_item,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_item
);

    localparam int POS_W = $clog2(MAX_CHARS + 1);

    logic             advance;
    logic             in_take;
    logic             process;
    logic             core_fire;
    out_item_t        core_result;
    parse_state_t     core_state;
    logic [POS_W-1:0] core_position;

    logic             in_valid_reg, in_valid_next;
    in_item_t         in_item_reg;
    parse_state_t     state_reg;
    logic [POS_W-1:0] position_reg;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg;
    logic [5:0]       number_base_reg;

    assign advance   = !(out_valid_reg && out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign process   = in_valid_reg && advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    s2u_parse_core #(
        .MAX_CHARS (MAX_CHARS)
    ) u_core (
        .string_start  (in_item_reg.string_start),
        .char_code     (in_item_reg.char_code),
        .number_base   (number_base_reg),
        .state         (state_reg),
        .position      (position_reg),
        .state_next    (core_state),
        .position_next (core_position),
        .fire          (core_fire),
        .result        (core_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = process && core_fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg                 <= 1'b0;
            out_valid_reg                <= 1'b0;
            number_base_reg              <= BASE_AUTO;
            state_reg.phase              <= PH_IDLE;
            state_reg.accumulator        <= '0;
            state_reg.negative_sign      <= 1'b0;
            state_reg.effective_base     <= BASE_AUTO;
            state_reg.any_status         <= ANY_NONE;
            position_reg                 <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                number_base_reg <= cfg_data;
            if (process)
            begin
                state_reg    <= core_state;
                position_reg <= core_position;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= in_item;
        if (process && core_fire)
            out_item_reg <= core_result;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("Input stalled while the output register can move.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (process && core_fire) |=> (out_valid && state_reg.phase == PH_DONE))
        else $error("A terminating byte did not produce a result and finish the string.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.overflow_flag) |-> (&out_item.parsed_value))
        else $error("Overflowed result is not saturated.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.digits_seen) |->
            (out_item.end_offset == 12'd0 && out_item.parsed_value == 64'd0 &&
             !out_item.overflow_flag))
        else $error("Result without digits carries a value or an offset.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg.phase))
        else $error("Parse phase is not one-hot.");

endmodule

`default_nettype wire
